@@ rtl/core/pjd_pkg.sv @@
// Package: shared types, codes and constants of the priority job dispatcher.
`timescale 1ns / 1ps
`default_nettype none
package pjd_pkg;

  localparam int TABLE_SLOTS_DEF = 16;
  localparam int MAX_WORKERS_DEF = 8;
  localparam int ORDER_W         = 16;

  localparam logic [2:0] OP_SUBMIT     = 3'd0;
  localparam logic [2:0] OP_CANCEL     = 3'd1;
  localparam logic [2:0] OP_CANCEL_ALL = 3'd2;
  localparam logic [2:0] OP_CLEAR      = 3'd3;
  localparam logic [2:0] OP_TAKE       = 3'd4;
  localparam logic [2:0] OP_COMPLETE   = 3'd5;
  localparam logic [2:0] OP_QUERY      = 3'd6;

  localparam logic [2:0] ST_QUEUED    = 3'd0;
  localparam logic [2:0] ST_RUNNING   = 3'd1;
  localparam logic [2:0] ST_SUCCEEDED = 3'd2;
  localparam logic [2:0] ST_FAILED    = 3'd3;
  localparam logic [2:0] ST_CANCELLED = 3'd4;

  localparam logic [1:0] PRIO_HIGH = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_NO_JOB  = 2'd2;
  localparam logic [1:0] STAT_BAD     = 2'd3;

  localparam logic CFG_WORKER_CAP   = 1'b0;
  localparam logic CFG_RESERVE_MODE = 1'b1;

  typedef struct packed {
    logic [2:0]         state;
    logic [1:0]         prio;
    logic               stop;
    logic [ORDER_W-1:0] order;
  } entry_t;

  // Ranking key of one job during a take scan.
  typedef struct packed {
    logic [1:0]         prio;
    logic [ORDER_W-1:0] age;
  } rank_t;

endpackage
`default_nettype wire

@@ rtl/core/priority_job_dispatcher.sv @@
// Top level: job table with priority dispatch to workers.
//
//  channel | dir | signals                      | contents
//  --------+-----+------------------------------+-------------------------------
//  s       | in  | s_tvalid s_tready s_tdata    | one command word per handshake
//  m       | out | m_tvalid m_tready m_tdata    | one response word per command
//  cfg     | in  | cfg_we cfg_index cfg_data    | worker cap, reserve mode
//
// Sweeps: cancel all, clear finished and take sweep the table, one slot per
// cycle through the job memory. Submit stops at the first free slot or, on a
// full table, answers full. Cancel, complete and query read one entry; a bad
// slot, a refused worker or an unknown opcode goes straight to the response.
// Reset (rst, synchronous) clears the valid flip-flops, order counter and
// control at once; no clearing pass. A command is taken while the previous
// response still waits in the output register; a stalled m_tready holds the
// finished response in the engine until free.
module priority_job_dispatcher #(
  parameter int TABLE_SLOTS = pjd_pkg::TABLE_SLOTS_DEF,
  parameter int MAX_WORKERS = pjd_pkg::MAX_WORKERS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // s_tdata from bit 0: opcode[2:0], priority_req[4:3], job_slot[8:5],
  // worker[11:9], outcome[13:12], zero pad [15:14]
  input  wire logic [15:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // m_tdata from bit 0: status[1:0], job_slot_out[5:2], job_state[8:6],
  // job_priority[10:9], zero pad [15:11]
  output logic [15:0]      m_tdata,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [3:0]  cfg_data
);
  import pjd_pkg::*;

  localparam int SW = $clog2(TABLE_SLOTS);
  localparam int CW = $clog2(TABLE_SLOTS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_ONE  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  // input word fields
  logic [2:0] in_op;
  logic [1:0] in_prio;
  logic [3:0] in_slot;
  logic [2:0] in_widx;
  logic [1:0] in_outc;
  assign in_op   = s_tdata[2:0];
  assign in_prio = s_tdata[4:3];
  assign in_slot = s_tdata[8:5];
  assign in_widx = s_tdata[11:9];
  assign in_outc = s_tdata[13:12];

  // configuration
  logic [3:0] worker_cap;
  logic       reserve_mode;

  // control and latched command
  logic [1:0]         state;
  logic [2:0]         op;
  logic [1:0]         prio_sat;
  logic [SW-1:0]      slot;
  logic [3:0]         slot_raw;
  logic [2:0]         widx;
  logic [1:0]         outc;
  logic [CW-1:0]      idx;
  logic               rd_pend;
  logic [SW-1:0]      rd_addr;
  logic [TABLE_SLOTS-1:0] valid;
  logic [ORDER_W-1:0] order_counter;

  // take scan bookkeeping
  logic          found;
  logic [SW-1:0] best_slot;
  entry_t        best_ent;
  rank_t         best_rank;

  // staged response
  logic [1:0] res_status;
  logic [3:0] res_slot;
  logic [2:0] res_state;
  logic [1:0] res_prio;

  // output register
  logic [1:0] out_status;
  logic [3:0] out_slot;
  logic [2:0] out_state;
  logic [1:0] out_prio;

  // job memory
  entry_t        mem [TABLE_SLOTS];
  entry_t        rdata;
  logic          rd_en;
  logic [SW-1:0] raddr;
  logic          mem_we;
  logic [SW-1:0] waddr;
  entry_t        wdata;

  logic   in_fire;
  logic   idx_live;
  logic   scan_end;
  logic   reserved_block;
  logic   beats;
  rank_t  cand_rank;
  logic   cand_ok;
  logic [2:0] done_state;

  assign s_tready = (state == S_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign idx_live = (32'(idx) < TABLE_SLOTS);
  assign scan_end = !idx_live && !rd_pend;

  assign cand_rank.prio = rdata.prio;
  assign cand_rank.age  = order_counter - rdata.order;
  assign cand_ok = rd_pend && valid[rd_addr] && (rdata.state == ST_QUEUED) && !rdata.stop;

  pjd_pick u_pick (
    .cand  (cand_rank),
    .best  (best_rank),
    .found (found),
    .beats (beats)
  );

  // In reserve mode with a cap above one, the last allowed worker only takes high priority work.
  assign reserved_block = reserve_mode && (worker_cap > 4'd1) &&
                          ({1'b0, widx} == (worker_cap - 4'd1)) &&
                          (best_rank.prio != PRIO_HIGH);

  // Completion outcome mapping for a running job.
  always_comb begin
    case (outc)
      2'd0:    done_state = rdata.stop ? ST_CANCELLED : ST_SUCCEEDED;
      2'd1:    done_state = rdata.stop ? ST_CANCELLED : ST_FAILED;
      default: done_state = ST_FAILED;
    endcase
  end

  // Memory port control.
  always_comb begin
    rd_en  = 1'b0;
    raddr  = idx[SW-1:0];
    mem_we = 1'b0;
    waddr  = rd_addr;
    wdata  = rdata;
    case (state)
      S_IDLE: begin
        rd_en = s_tvalid;
        raddr = SW'(in_slot);
      end
      S_SCAN: begin
        if (op == OP_SUBMIT) begin
          if (idx_live && !valid[idx[SW-1:0]]) begin
            mem_we      = 1'b1;
            waddr       = idx[SW-1:0];
            wdata.state = ST_QUEUED;
            wdata.prio  = prio_sat;
            wdata.stop  = 1'b0;
            wdata.order = order_counter;
          end
        end else begin
          rd_en = idx_live;
          if (op == OP_CANCEL_ALL && rd_pend && valid[rd_addr]) begin
            mem_we     = 1'b1;
            wdata.stop = 1'b1;
            if (rdata.state == ST_QUEUED) wdata.state = ST_CANCELLED;
          end
          if (op == OP_TAKE && scan_end && found && !reserved_block) begin
            mem_we      = 1'b1;
            waddr       = best_slot;
            wdata       = best_ent;
            wdata.state = ST_RUNNING;
          end
        end
      end
      S_ONE: begin
        waddr = slot;
        if (op == OP_CANCEL) begin
          mem_we     = 1'b1;
          wdata.stop = 1'b1;
          if (rdata.state == ST_QUEUED) wdata.state = ST_CANCELLED;
        end else if (op == OP_COMPLETE && rdata.state == ST_RUNNING) begin
          mem_we      = 1'b1;
          wdata.state = done_state;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    if (rd_en) rdata <= mem[raddr];
  end

  // Configuration writes, clamped to the allowed worker range.
  always_ff @(posedge clk) begin
    if (rst) begin
      worker_cap   <= (MAX_WORKERS < 4) ? 4'(MAX_WORKERS) : 4'd4;
      reserve_mode <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_WORKER_CAP) begin
        if (cfg_data == 4'd0) worker_cap <= 4'd1;
        else if (32'(cfg_data) > MAX_WORKERS) worker_cap <= 4'(MAX_WORKERS);
        else worker_cap <= cfg_data;
      end else begin
        reserve_mode <= cfg_data[0];
      end
    end
  end

  // Command engine.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      valid         <= '0;
      order_counter <= '0;
      rd_pend       <= 1'b0;
      found         <= 1'b0;
      idx           <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      // drop the word once taken, unless a new one loads in the same cycle
      if (m_tvalid && m_tready && state != S_DONE) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            op       <= in_op;
            prio_sat <= (in_prio > PRIO_HIGH) ? PRIO_HIGH : in_prio;
            slot     <= SW'(in_slot);
            slot_raw <= in_slot;
            widx     <= in_widx;
            outc     <= in_outc;
            idx      <= '0;
            rd_pend  <= 1'b0;
            found    <= 1'b0;
            res_status <= (in_op == OP_TAKE && {1'b0, in_widx} >= worker_cap) ?
                          STAT_NO_JOB : STAT_BAD;
            res_slot   <= '0;
            res_state  <= '0;
            res_prio   <= '0;
            case (in_op)
              OP_SUBMIT, OP_CANCEL_ALL, OP_CLEAR: state <= S_SCAN;
              OP_TAKE: begin
                if ({1'b0, in_widx} >= worker_cap) begin
                  state <= S_DONE;
                end else begin
                  state <= S_SCAN;
                end
              end
              OP_CANCEL, OP_COMPLETE, OP_QUERY: begin
                // reject slots beyond the table or not in use
                if (32'(in_slot) < TABLE_SLOTS && valid[SW'(in_slot)]) state <= S_ONE;
                else state <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_SCAN: begin
          if (op == OP_SUBMIT) begin
            if (!idx_live) begin
              res_status <= STAT_FULL;
              state      <= S_DONE;
            end else if (!valid[idx[SW-1:0]]) begin
              valid[idx[SW-1:0]] <= 1'b1;
              order_counter      <= order_counter + 1'b1;
              res_status <= STAT_OK;
              res_slot   <= 4'(idx);
              res_state  <= ST_QUEUED;
              res_prio   <= prio_sat;
              state      <= S_DONE;
            end else begin
              idx <= idx + 1'b1;
            end
          end else begin
            // advance the read sweep; the previous slot's data is in rdata
            rd_pend <= idx_live;
            rd_addr <= idx[SW-1:0];
            if (idx_live) idx <= idx + 1'b1;
            if (op == OP_CLEAR && rd_pend && valid[rd_addr] &&
                rdata.state >= ST_SUCCEEDED) begin
              valid[rd_addr] <= 1'b0;
            end
            if (op == OP_TAKE && cand_ok && beats) begin
              found     <= 1'b1;
              best_slot <= rd_addr;
              best_ent  <= rdata;
              best_rank <= cand_rank;
            end
            if (scan_end) begin
              state <= S_DONE;
              if (op == OP_TAKE) begin
                if (found && !reserved_block) begin
                  res_status <= STAT_OK;
                  res_slot   <= 4'(best_slot);
                  res_state  <= ST_RUNNING;
                  res_prio   <= best_rank.prio;
                end else begin
                  res_status <= STAT_NO_JOB;
                end
              end else begin
                res_status <= STAT_OK;
              end
            end
          end
        end
        S_ONE: begin
          state <= S_DONE;
          if (op == OP_COMPLETE && rdata.state != ST_RUNNING) begin
            res_status <= STAT_BAD;
          end else begin
            res_status <= STAT_OK;
            res_slot   <= slot_raw;
            res_prio   <= rdata.prio;
            res_state  <= mem_we ? wdata.state : rdata.state;
          end
        end
        default: begin
          // hold the response until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            out_status <= res_status;
            out_slot   <= res_slot;
            out_state  <= res_state;
            out_prio   <= res_prio;
            state      <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign m_tdata = {5'd0, out_prio, out_state, out_slot, out_status};

endmodule
`default_nettype wire

@@ rtl/core/pjd_pick.sv @@
// Ranking compare: does a candidate job beat the best one found so far.
`timescale 1ns / 1ps
`default_nettype none
module pjd_pick (
  input  pjd_pkg::rank_t cand,
  input  pjd_pkg::rank_t best,
  input  logic           found,
  output logic           beats
);
  import pjd_pkg::*;

  // Higher priority wins; on a tie the larger age (older job) wins.
  assign beats = !found || (cand.prio > best.prio) ||
                 ((cand.prio == best.prio) && (cand.age > best.age));

endmodule
`default_nettype wire
